### rtl/tii_pkg.sv
// Shared widths, limits and register indexes for the thresholded integral image block.
// No dependencies; imported by thresholded_integral_image.
package tii_pkg;

    localparam int PIXEL_W   = 8;
    localparam int AREA_W    = 23;
    localparam int ROW_SUM_W = 12;
    localparam int CFG_W     = 12;
    localparam int THRESH_W  = 8;

    localparam logic [ROW_SUM_W-1:0] ROW_SUM_MAX  = '1;
    localparam logic [AREA_W-1:0]    AREA_FIELD_MAX = '1;

    // configuration register indexes
    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_LINE_WIDTH = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 12'd2048;

endpackage

### rtl/thresholded_integral_image.sv
// Thresholded integral image: per-pixel summed-area value of a binarized raster stream.
// Depends on tii_pkg. Holds the previous row's sums in a single-port-write,
// registered-read line memory of MAX_WIDTH entries.
//
// Usage:
//   s_ side: one pixel per request, s_tdata = pixel, s_tuser = frame_start.
//   m_ side: one area_sum per pixel, same order, in m_tdata.
//   Configuration (threshold, line_width) is written through cfg_we / cfg_index /
//   cfg_wdata while the stream is idle; it takes effect on the next pixel.
//   Throughput: one pixel per cycle while m_tready stays high. An accepted pixel
//   passes the line memory read register, then the add and output register,
//   before m_tvalid rises.
//   The memory is read when a pixel is accepted and written back when that pixel
//   moves to the output register; a read of the entry being written that same
//   cycle (one-pixel rows) takes the written value from a forwarding register.
//   Reset clears the column counter, row count, first-row flag and both valid
//   flags; the line memory is not cleared, since the first row of every image
//   never reads it.
//   When m_tready is low the result holds in the output register, one more pixel
//   waits in the read stage, and s_tready drops once both are full.
module thresholded_integral_image
    import tii_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [7:0] pixel
    input  logic                  s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [22:0] area_sum
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [63:0] CAP_FULL = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT);
    localparam logic [AREA_W-1:0] AREA_CAP =
        (CAP_FULL > 64'(AREA_FIELD_MAX)) ? AREA_FIELD_MAX : AREA_W'(CAP_FULL);

    logic [THRESH_W-1:0]  threshold_reg;
    logic [CFG_W-1:0]     line_width_reg;

    logic [AW-1:0]        col_reg;
    logic [ROW_SUM_W-1:0] rsum_reg;
    logic                 first_reg;

    logic                 s1_valid_reg;
    logic [AW-1:0]        s1_col_reg;
    logic [ROW_SUM_W-1:0] s1_rsum_reg;
    logic                 s1_first_reg;
    logic                 fwd_reg;
    logic [AREA_W-1:0]    fwd_data_reg;
    logic [AREA_W-1:0]    rd_data_reg;

    logic                 out_valid_reg;
    logic [AREA_W-1:0]    out_data_reg;

    logic [AREA_W-1:0]    row_mem [MAX_WIDTH];

    logic                 accept;
    logic                 out_free;
    logic                 s1_move;
    logic [WW-1:0]        width_eff;
    logic [AW-1:0]        col_cur;
    logic [ROW_SUM_W-1:0] rsum_base;
    logic                 first_base;
    logic [ROW_SUM_W-1:0] rsum_next;
    logic [WW-1:0]        col_inc;
    logic                 row_end;
    logic [AREA_W-1:0]    above;
    logic [AREA_W:0]      sum_wide;
    logic [AREA_W-1:0]    total;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // line_width of 0 acts as 1, above MAX_WIDTH clamps
    always_comb begin
        if (line_width_reg == '0) begin
            width_eff = WW'(1);
        end else if (32'(line_width_reg) > 32'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(line_width_reg);
        end
    end

    always_comb begin
        col_cur    = s_tuser ? '0 : col_reg;
        rsum_base  = s_tuser ? '0 : rsum_reg;
        first_base = s_tuser ? 1'b1 : first_reg;
        if (s_tdata > threshold_reg && rsum_base != ROW_SUM_MAX) begin
            rsum_next = rsum_base + ROW_SUM_W'(1);
        end else begin
            rsum_next = rsum_base;
        end
        col_inc = WW'(col_cur) + WW'(1);
        row_end = (col_inc >= width_eff);
    end

    always_comb begin
        if (s1_first_reg) begin
            above = '0;
        end else if (fwd_reg) begin
            above = fwd_data_reg;
        end else begin
            above = rd_data_reg;
        end
        sum_wide = {1'b0, above} + (AREA_W + 1)'(s1_rsum_reg);
        total    = (sum_wide > (AREA_W + 1)'(AREA_CAP)) ? AREA_CAP : sum_wide[AREA_W-1:0];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= '0;
            line_width_reg <= LINE_WIDTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_wdata[THRESH_W-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // row position state, advanced at each accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            rsum_reg  <= '0;
            first_reg <= 1'b1;
        end else if (accept) begin
            if (row_end) begin
                col_reg   <= '0;
                rsum_reg  <= '0;
                first_reg <= 1'b0;
            end else begin
                col_reg   <= col_inc[AW-1:0];
                rsum_reg  <= rsum_next;
                first_reg <= first_base;
            end
        end
    end

    // line memory: read on accept, write back when the read stage retires
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            row_mem[s1_col_reg] <= total;
        end
        if (accept) begin
            rd_data_reg <= row_mem[col_cur];
        end
    end

    // read stage payload and output data register
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= col_cur;
            s1_rsum_reg  <= rsum_next;
            s1_first_reg <= first_base;
            fwd_reg      <= s1_move && (s1_col_reg == col_cur);
            fwd_data_reg <= total;
        end
        if (s1_move) begin
            out_data_reg <= total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

### test/thresholded_integral_image_tb.sv
// Testbench for thresholded_integral_image: drives raster pixel streams, predicts every
// area sum in-line and checks results in order. Depends on tii_pkg and the block RTL.
`timescale 1ns / 100ps

module thresholded_integral_image_tb;
    import tii_pkg::*;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int LATENCY    = 2;
    localparam int AREA_CAP   = (MAX_WIDTH * MAX_HEIGHT > int'(AREA_FIELD_MAX)) ?
                                int'(AREA_FIELD_MAX) : MAX_WIDTH * MAX_HEIGHT;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [PIXEL_W-1:0]   s_tdata = '0;    // [7:0] pixel
    logic                 s_tuser = 1'b0;  // [0] frame_start
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;         // [22:0] area_sum
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = REG_THRESHOLD;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    thresholded_integral_image #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // shadow of the block's registers and row state
    logic [THRESH_W-1:0]  thresh_shadow = '0;
    logic [CFG_W-1:0]     width_shadow = LINE_WIDTH_RESET;
    logic [AREA_W-1:0]    prev_row_sums [MAX_WIDTH];
    bit                   row_written [MAX_WIDTH];
    int                   row_count = 0;
    int                   col_next = 0;
    bit                   first_row_flag = 1'b1;

    logic [AREA_W-1:0]    area_sums_due [$];
    int                   mismatches = 0;
    int                   pixels_sent = 0;
    int                   frame_left = 0;
    bit                   idle_on = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int eff_width();
        if (width_shadow == 0)
            return 1;
        if (width_shadow > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_shadow);
    endfunction

    function automatic logic [AREA_W-1:0] predict_area_sum(input logic [PIXEL_W-1:0] pix,
                                                           input logic fs);
        int w;
        int col;
        int total;
        w = eff_width();
        if (fs) begin
            col_next = 0;
            row_count = 0;
            first_row_flag = 1'b1;
        end
        col = (col_next >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_next;
        if (pix > thresh_shadow && row_count < int'(ROW_SUM_MAX))
            row_count++;
        total = (first_row_flag ? 0 : int'(prev_row_sums[col])) + row_count;
        if (total > AREA_CAP)
            total = AREA_CAP;
        prev_row_sums[col] = total[AREA_W-1:0];
        row_written[col] = 1'b1;
        if (col + 1 >= w) begin
            col_next = 0;
            row_count = 0;
            first_row_flag = 1'b0;
        end else begin
            col_next = col + 1;
        end
        return total[AREA_W-1:0];
    endfunction

    // result checker
    always @(posedge aclk) begin
        logic [AREA_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (area_sums_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d", $time,
                         m_tdata[AREA_W-1:0]);
                mismatches++;
            end else begin
                want = area_sums_due.pop_front();
                if (m_tdata[AREA_W-1:0] !== want) begin
                    $display("%0t: area_sum mismatch, expected %0d, got %0d", $time, want,
                             m_tdata[AREA_W-1:0]);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure
    always begin
        @(posedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
        logic [AREA_W-1:0] want;
        // a row never written must not be read: start a new image instead
        if (!fs && !first_row_flag && !row_written[col_next])
            fs = 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        want = predict_area_sum(pix, fs);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        area_sums_due.push_back(want);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (area_sums_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic set_register(input logic idx, input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD)
            thresh_shadow = val[THRESH_W-1:0];
        else
            width_shadow = val;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int t;
        case ($urandom_range(0, 2))
            0: return PIXEL_W'($urandom_range(0, 255));
            1: begin
                t = int'(thresh_shadow) + int'($urandom_range(0, 2)) - 1;
                return (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[PIXEL_W-1:0];
            end
            default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // well-formed frames of random height, with an occasional stray frame start
    task automatic stream_frames(input int count);
        logic fs;
        repeat (count) begin
            fs = (frame_left <= 0);
            if (fs)
                frame_left = int'($urandom_range(1, 5)) * eff_width();
            else if ($urandom_range(0, 39) == 0)
                fs = 1'b1;
            frame_left--;
            send_pixel(pick_pixel(), fs);
        end
    endtask

    task automatic test_reset_defaults();
        // threshold 0, width 2048 from reset; no frame start on the first pixel
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd128, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd77, 1'b0);
    endtask

    task automatic test_width_changes();
        // shrink mid-row: the column is past the new width, so the row ends now
        set_register(REG_LINE_WIDTH, 12'd3);
        repeat (5) send_pixel(PIXEL_W'($urandom_range(0, 255)), 1'b0);
        set_register(REG_THRESHOLD, 12'd255);
        repeat (3) send_pixel(8'd255, 1'b0);
        set_register(REG_THRESHOLD, 12'd254);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b0);
        // zero acts as one-pixel rows
        set_register(REG_LINE_WIDTH, 12'd0);
        repeat (3) send_pixel(8'd255, 1'b0);
        // above the maximum acts as the maximum
        set_register(REG_LINE_WIDTH, 12'hFFF);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        set_register(REG_LINE_WIDTH, 12'd2049);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd255, 1'b1);
    endtask

    task automatic test_random_frames();
        while (pixels_sent < 1680) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 4))
                    0: set_register(REG_THRESHOLD, 12'd0);
                    1: set_register(REG_THRESHOLD, 12'd255);
                    default: set_register(REG_THRESHOLD, CFG_W'($urandom_range(0, 255)));
                endcase
            end
            case ($urandom_range(0, 11))
                0: set_register(REG_LINE_WIDTH, 12'd0);
                1: set_register(REG_LINE_WIDTH, 12'd1);
                2: set_register(REG_LINE_WIDTH, 12'hFFF);
                3: set_register(REG_LINE_WIDTH, 12'd2048);
                4: set_register(REG_LINE_WIDTH, 12'd2049);
                5: set_register(REG_LINE_WIDTH, CFG_W'($urandom_range(20, 80)));
                default: set_register(REG_LINE_WIDTH, CFG_W'($urandom_range(2, 12)));
            endcase
            // half the phases carry the current image on across the width change
            if ($urandom_range(0, 1) != 0)
                frame_left = 0;
            stream_frames(int'($urandom_range(80, 200)));
        end
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        set_register(REG_THRESHOLD, 12'd128);
        set_register(REG_LINE_WIDTH, 12'd7);
        frame_left = 0;
        stream_frames(120);
        set_register(REG_LINE_WIDTH, 12'd1);
        stream_frames(80);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_width_changes();
        test_random_frames();
        test_full_rate();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
